@@ rtl/core/sorb_pkg.sv @@
// Package for the spiral-order reorder buffer.
// Holds the shared types, register indexes and controller/datapath interface structs.
// No dependencies.
`default_nettype none

package sorb_pkg;

  // Fixed width of the element field on both streams.
  localparam int unsigned ELEM_W = 32;

  // Width of the configuration write data (widest register).
  localparam int unsigned CFG_W = 4;

  // Configuration register indexes.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_LOAD,
    ST_WALK
  } state_t;

  // Direction of the spiral walk.
  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;     // store the accepted input word
    logic walk_start;  // set up the boundary registers for a new spiral
    logic walk_step;   // issue one store read and advance the walk
  } sorb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_last;   // the next stored word completes the matrix
    logic walk_last;   // the current walk position is the final cell
    logic out_room;    // the output queue can take one more read
  } sorb_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/sorb_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module sorb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sorb_ctrl.sv @@
// Controller for the spiral-order reorder buffer: load and walk state machine.
// Depends on sorb_pkg for the state type and the command/status structs.
`default_nettype none

module sorb_ctrl
  import sorb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire sorb_stat_t stat,
  output sorb_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd.load_we    = 1'b0;
    cmd.walk_start = 1'b0;
    cmd.walk_step  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready   = 1'b1;
        cmd.load_we = in_tvalid;
        if (in_tvalid && stat.load_last) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_step = stat.out_room;
        if (stat.out_room && stat.walk_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // The word that completes a matrix always hands over to the walk.
  a_load_to_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_we && stat.load_last) |=> (state_r == ST_WALK))
    else $error("completed load did not start the walk");

  // Reads and writes of the store never happen in the same phase.
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_we && cmd.walk_step))
    else $error("load and walk commands overlap");

endmodule

`default_nettype wire

@@ rtl/core/sorb_dp.sv @@
// Datapath of the spiral-order reorder buffer: size registers, load counter,
// spiral address walker, matrix store and a two-entry output queue.
// Depends on sorb_pkg and sorb_ram.
`default_nettype none

module sorb_dp
  import sorb_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = 8,
  parameter int unsigned MAX_COLS   = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic [ELEM_W-1:0] in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [ELEM_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  wire sorb_cmd_t         cmd,
  output sorb_stat_t             stat
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW    = $clog2(DEPTH + 1);
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RCW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW   = $clog2(MAX_COLS + 1);
  localparam int unsigned PW    = RCW + CCW + RW + CW;

  // Size registers, reset to the default of eight clamped to the maximum.
  localparam int unsigned ROWS_RST = (MAX_ROWS < 8) ? MAX_ROWS : 8;
  localparam int unsigned COLS_RST = (MAX_COLS < 8) ? MAX_COLS : 8;

  logic [RCW-1:0] rows_r, rows_nxt;
  logic [CCW-1:0] cols_r, cols_nxt;
  logic [TW-1:0]  load_cnt_r;
  logic [TW-1:0]  total;

  always_comb begin
    if (cfg_wdata == '0) begin
      rows_nxt = RCW'(1);
      cols_nxt = CCW'(1);
    end else begin
      rows_nxt = (cfg_wdata > CFG_W'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(cfg_wdata);
      cols_nxt = (cfg_wdata > CFG_W'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= RCW'(ROWS_RST);
      cols_r     <= CCW'(COLS_RST);
      load_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        // Any register write drops a partly loaded matrix.
        load_cnt_r <= '0;
        if (cfg_index == REG_ROWS) begin
          rows_r <= rows_nxt;
        end else begin
          cols_r <= cols_nxt;
        end
      end else if (cmd.load_we) begin
        load_cnt_r <= stat.load_last ? '0 : load_cnt_r + TW'(1);
      end
    end
  end

  assign total          = TW'(PW'(rows_r) * PW'(cols_r));
  assign stat.load_last = (load_cnt_r == total - TW'(1));

  // Spiral walker: current cell, direction and four shrinking boundaries.
  logic [RW-1:0] row_r, top_r, bot_r;
  logic [CW-1:0] col_r, lft_r, rgt_r;
  dir_t          dir_r;
  logic [TW-1:0] walk_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      row_r      <= '0;
      col_r      <= '0;
      top_r      <= '0;
      lft_r      <= '0;
      bot_r      <= RW'(rows_r - RCW'(1));
      rgt_r      <= CW'(cols_r - CCW'(1));
      dir_r      <= DIR_RIGHT;
      walk_cnt_r <= '0;
    end else if (cmd.walk_step) begin
      walk_cnt_r <= walk_cnt_r + TW'(1);
      case (dir_r)
        DIR_RIGHT: begin
          if (col_r == rgt_r) begin
            dir_r <= DIR_DOWN;
            top_r <= top_r + RW'(1);
            row_r <= row_r + RW'(1);
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
        DIR_DOWN: begin
          if (row_r == bot_r) begin
            dir_r <= DIR_LEFT;
            rgt_r <= rgt_r - CW'(1);
            col_r <= col_r - CW'(1);
          end else begin
            row_r <= row_r + RW'(1);
          end
        end
        DIR_LEFT: begin
          if (col_r == lft_r) begin
            dir_r <= DIR_UP;
            bot_r <= bot_r - RW'(1);
            row_r <= row_r - RW'(1);
          end else begin
            col_r <= col_r - CW'(1);
          end
        end
        DIR_UP: begin
          if (row_r == top_r) begin
            dir_r <= DIR_RIGHT;
            lft_r <= lft_r + CW'(1);
            col_r <= col_r + CW'(1);
          end else begin
            row_r <= row_r - RW'(1);
          end
        end
        default: begin
          dir_r <= DIR_RIGHT;
        end
      endcase
    end
  end

  assign stat.walk_last = (walk_cnt_r == total - TW'(1));

  // Row-major store address of the current walk cell.
  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'(PW'(row_r) * PW'(cols_r) + PW'(col_r));

  // Element width adaption on the way in and on the way out.
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [ELEM_W-1:0]     rd_elem;

  if (DATA_WIDTH <= ELEM_W) begin : g_in_narrow
    assign wr_data = in_tdata[DATA_WIDTH-1:0];
  end else begin : g_in_wide
    assign wr_data = {{(DATA_WIDTH-ELEM_W){in_tdata[ELEM_W-1]}}, in_tdata};
  end

  if (DATA_WIDTH >= ELEM_W) begin : g_out_wide
    assign rd_elem = rd_data[ELEM_W-1:0];
  end else begin : g_out_narrow
    assign rd_elem = {{(ELEM_W-DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
  end

  sorb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (AW'(load_cnt_r)),
    .wdata (wr_data),
    .re    (cmd.walk_step),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Read in flight: the store data is valid in the cycle after the read.
  logic rd_vld_r;
  logic rd_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      rd_last_r <= stat.walk_last;
    end
  end

  // Two-entry output queue so a stalled sink does not lose a read in flight.
  logic [ELEM_W-1:0] q_data_r [2];
  logic              q_last_r [2];
  logic              q_wptr_r, q_rptr_r;
  logic [1:0]        q_cnt_r;
  logic              pop;
  logic [2:0]        occ;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = q_data_r[q_rptr_r];
  assign out_tlast  = q_last_r[q_rptr_r];

  // Entries held plus the read in flight; a new read needs a free slot.
  assign occ           = {1'b0, q_cnt_r} + {2'b00, rd_vld_r};
  assign stat.out_room = (occ < 3'd2) || ((occ == 3'd2) && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wptr_r <= 1'b0;
      q_rptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (rd_vld_r) begin
        q_wptr_r <= ~q_wptr_r;
      end
      if (pop) begin
        q_rptr_r <= ~q_rptr_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, rd_vld_r} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      q_data_r[q_wptr_r] <= rd_elem;
      q_last_r[q_wptr_r] <= rd_last_r;
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("output queue count out of range");

  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && !pop) |-> (q_cnt_r < 2'd2))
    else $error("store read arrived at a full output queue");

  a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> (row_r >= top_r && row_r <= bot_r &&
                       col_r >= lft_r && col_r <= rgt_r))
    else $error("spiral walk left the current boundaries");

endmodule

`default_nettype wire

@@ rtl/core/spiral_order_reorder_buffer.sv @@
// Spiral-order reorder buffer: loads rows*cols words at one word per cycle, then
// emits them in clockwise spiral order at one word per cycle while the sink is ready.
// The first result follows the completing word through the state register, the store
// read and the output queue. The input is held off while the walk reads the single
// matrix store, so loading and walking take turns. Reset (rst_n, synchronous,
// active low) sets rows and cols to 8, clamped to MAX_ROWS/MAX_COLS, and empties the load.
`default_nettype none

module spiral_order_reorder_buffer
  import sorb_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = 8,
  parameter int unsigned MAX_COLS   = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration write port: index 0 is rows, index 1 is cols.
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  // Input stream.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [ELEM_W-1:0] in_tdata,   // [31:0] element
  // Result stream.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [ELEM_W-1:0] out_tdata,  // [31:0] element_out
  output logic                   out_tlast
);

  // The controller takes input words while loading. Once the word that completes
  // the matrix is accepted, it switches to walking: each cycle with room in the
  // output queue it issues one store read at the next spiral cell. After the read
  // of the final cell it returns to loading; the queue drains on its own. The
  // final word of each spiral carries out_tlast.

  sorb_cmd_t  cmd;
  sorb_stat_t stat;

  sorb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sorb_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire
